// File: hdl/bis_pkg.sv
package bis_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOOST_MODE         = 3'd0,
    CFG_IGNITION_LEVEL     = 3'd1,
    CFG_PAUSE_LEVEL        = 3'd2,
    CFG_FAN_SPEED_LIMIT    = 3'd3,
    CFG_FIRE_VALVE_PATTERN = 3'd4,
    CFG_RETRY_COUNT        = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    NS_STAY   = 2'd0,
    NS_STABLE = 2'd1,
    NS_DEBUG  = 2'd2,
    NS_END    = 2'd3
  } next_state_t;

  typedef enum logic [3:0] {
    FLT_NONE = 4'd0,
    FLT_E1   = 4'd1,
    FLT_E6   = 4'd2,
    FLT_E3   = 4'd3,
    FLT_E2   = 4'd4,
    FLT_E8   = 4'd5,
    FLT_E4   = 4'd6,
    FLT_F3   = 4'd7,
    FLT_F5   = 4'd8
  } fault_t;

  // phase timer limits, in 10 ms ticks
  localparam logic [10:0] PurgeEnd   = 11'd40;
  localparam logic [10:0] RampEnd    = 11'd50;
  localparam logic [10:0] PauseStart = 11'd800;
  localparam logic [10:0] Reignite   = 11'd1100;

  localparam logic [7:0]  ProvenTicks    = 8'd30;
  localparam logic [15:0] FlameLossLimit = 16'd100;
  localparam logic [15:0] StallLimit     = 16'd100;
  localparam logic [15:0] OverspeedLimit = 16'd50;
  localparam logic [8:0]  BoostStep      = 9'd5;
  localparam logic [7:0]  FullBlower     = 8'hff;

  typedef struct packed {
    logic        igniter_on;
    logic [7:0]  valve_out;
    logic [7:0]  blower_level;
    logic        blower_off;
    logic [7:0]  fan_drive_level;
    logic        dc_fan_off;
    next_state_t next_state;
    fault_t      fault_code;
  } result_t;

endpackage

// File: hdl/burner_ignition_sequencer.sv
// Burner ignition sequencer. Each accepted item is either a start (action 0),
// which clears the counters, loads retry_count and returns an all-zero result,
// or one 10 ms tick (action 1), which advances the phase timer (purge, ramp,
// spark, pause, re-ignite at 1100 ticks) and runs the fault checks. Exactly one
// result per item, in order. Unless stalled, an item is accepted every cycle
// and its result registered. A two-entry output buffer (result register plus
// skid register) keeps item_stall registered; item_stall rises only when both
// entries hold results the downstream side has not taken. Configuration writes
// are always ready and take effect on the next cycle.
module burner_ignition_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bis_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic        flame_present,
  input  logic        water_flow,
  input  logic        burn_allowed,
  input  logic        thermal_switch,
  input  logic        valve_fault,
  input  logic        fan_running,
  input  logic [15:0] fan_speed,
  input  logic        outlet_probe_fault,
  input  logic        inlet_probe_fault,
  input  logic        flue_probe_fault,
  input  logic        debug_mode,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        igniter_on,
  output logic [7:0]  valve_out,
  output logic [7:0]  blower_level,
  output logic        blower_off,
  output logic [7:0]  fan_drive_level,
  output logic        dc_fan_off,
  output logic [1:0]  next_state,
  output logic [3:0]  fault_code
);
  import bis_pkg::*;

  // configuration registers
  logic        boost_mode;
  logic [7:0]  ignition_level;
  logic [7:0]  pause_level;
  logic [15:0] fan_speed_limit;
  logic [7:0]  fire_valve_pattern;
  logic [7:0]  retry_count;

  // sequencer state
  logic [10:0] phase_ticks,       phase_ticks_next;
  logic [7:0]  retries_left,      retries_left_next;
  logic [7:0]  flame_ticks,       flame_ticks_next;
  logic [15:0] flame_loss_ticks,  flame_loss_ticks_next;
  logic [15:0] stall_ticks,       stall_ticks_next;
  logic [15:0] speed_fault_ticks, speed_fault_ticks_next;

  // output buffer
  result_t res, res_next, skid;
  logic    skid_valid;

  logic item_accept, res_taken;

  logic [8:0]  level_sum;
  logic [7:0]  level;
  logic [10:0] phase_inc;
  logic [7:0]  flame_mid;
  logic [15:0] loss_mid, stall_mid, speed_mid;
  logic        spark, proven;

  assign cfg_ready   = 1'b1;
  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !item_stall;
  assign res_taken   = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_mode         <= 1'b0;
      ignition_level     <= 8'd0;
      pause_level        <= 8'd0;
      fan_speed_limit    <= 16'hffff;
      fire_valve_pattern <= 8'd0;
      retry_count        <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BOOST_MODE:         boost_mode         <= cfg_data[0];
        CFG_IGNITION_LEVEL:     ignition_level     <= cfg_data[7:0];
        CFG_PAUSE_LEVEL:        pause_level        <= cfg_data[7:0];
        CFG_FAN_SPEED_LIMIT:    fan_speed_limit    <= cfg_data;
        CFG_FIRE_VALVE_PATTERN: fire_valve_pattern <= cfg_data[7:0];
        CFG_RETRY_COUNT:        retry_count        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level_sum = {1'b0, ignition_level};
    if (boost_mode || retries_left == 8'd0) begin
      level_sum = level_sum + BoostStep;
    end
    level = level_sum[8] ? FullBlower : level_sum[7:0];

    phase_inc = phase_ticks + 11'd1;
    spark  = 1'b0;
    proven = 1'b0;

    res_next = '0;
    res_next.next_state = NS_STAY;
    res_next.fault_code = FLT_NONE;

    phase_ticks_next  = phase_inc;
    retries_left_next = retries_left;
    flame_mid         = flame_ticks;
    loss_mid          = flame_loss_ticks;

    if (!action) begin
      phase_ticks_next       = '0;
      retries_left_next      = retry_count;
      flame_ticks_next       = '0;
      flame_loss_ticks_next  = '0;
      stall_ticks_next       = '0;
      speed_fault_ticks_next = '0;
      stall_mid              = '0;
      speed_mid              = '0;
    end else begin
      if (phase_inc <= PurgeEnd) begin
        res_next.igniter_on      = 1'b1;
        res_next.blower_level    = FullBlower;
        res_next.fan_drive_level = level;
        loss_mid                 = '0;
      end else if (phase_inc <= RampEnd) begin
        res_next.igniter_on      = 1'b1;
        res_next.blower_level    = level;
        res_next.fan_drive_level = level;
        loss_mid                 = '0;
      end else if (phase_inc >= Reignite) begin
        if (retries_left != 8'd0) begin
          retries_left_next = retries_left - 8'd1;
        end
        phase_ticks_next         = '0;
        res_next.igniter_on      = 1'b1;
        res_next.blower_level    = FullBlower;
        res_next.fan_drive_level = level;
        loss_mid                 = '0;
      end else if (phase_inc >= PauseStart) begin
        if (retries_left == 8'd0) begin
          res_next.fault_code = FLT_E1;
          res_next.next_state = NS_END;
        end
        res_next.blower_off      = 1'b1;
        res_next.fan_drive_level = pause_level;
      end else begin
        spark                    = 1'b1;
        res_next.igniter_on      = 1'b1;
        res_next.valve_out       = fire_valve_pattern;
        res_next.blower_level    = level;
        res_next.fan_drive_level = level;
      end

      // flame proven while sparking
      proven = spark && (flame_ticks > ProvenTicks);
      if (proven) begin
        flame_mid           = '0;
        res_next.igniter_on = 1'b0;
        res_next.next_state = debug_mode ? NS_DEBUG : NS_STABLE;
      end

      if (flame_present) begin
        flame_ticks_next      = (flame_mid == 8'hff) ? flame_mid : flame_mid + 8'd1;
        flame_loss_ticks_next = (loss_mid == 16'hffff) ? loss_mid : loss_mid + 16'd1;
      end else begin
        flame_ticks_next      = '0;
        flame_loss_ticks_next = '0;
      end
      if (flame_loss_ticks_next >= FlameLossLimit) begin
        res_next.fault_code = FLT_E6;
        res_next.next_state = NS_END;
      end

      if (!burn_allowed || !water_flow) begin
        res_next.next_state = NS_END;
      end

      if (thermal_switch || valve_fault) begin
        res_next.fault_code = FLT_E3;
        res_next.next_state = NS_END;
      end

      stall_mid        = fan_running ? 16'd0 : stall_ticks;
      stall_ticks_next = (stall_mid == 16'hffff) ? stall_mid : stall_mid + 16'd1;
      if (stall_ticks_next >= StallLimit) begin
        res_next.dc_fan_off = 1'b1;
        res_next.fault_code = FLT_E2;
        res_next.next_state = NS_END;
      end

      speed_mid              = (fan_speed < fan_speed_limit) ? 16'd0 : speed_fault_ticks;
      speed_fault_ticks_next = (speed_mid == 16'hffff) ? speed_mid : speed_mid + 16'd1;
      if (speed_fault_ticks_next >= OverspeedLimit) begin
        res_next.fault_code = FLT_E8;
        res_next.next_state = NS_END;
      end

      // flue probe wins over inlet, inlet over outlet
      if (flue_probe_fault) begin
        res_next.fault_code = FLT_F5;
        res_next.next_state = NS_END;
      end else if (inlet_probe_fault) begin
        res_next.fault_code = FLT_F3;
        res_next.next_state = NS_END;
      end else if (outlet_probe_fault) begin
        res_next.fault_code = FLT_E4;
        res_next.next_state = NS_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= '0;
      retries_left      <= '0;
      flame_ticks       <= '0;
      flame_loss_ticks  <= '0;
      stall_ticks       <= '0;
      speed_fault_ticks <= '0;
    end else if (item_accept) begin
      phase_ticks       <= phase_ticks_next;
      retries_left      <= retries_left_next;
      flame_ticks       <= flame_ticks_next;
      flame_loss_ticks  <= flame_loss_ticks_next;
      stall_ticks       <= stall_ticks_next;
      speed_fault_ticks <= speed_fault_ticks_next;
    end
  end

  // result register plus skid entry; skid only fills while the result is held
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (res_taken) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (item_accept) begin
      if (!result_valid || res_taken) begin
        res          <= res_next;
        result_valid <= 1'b1;
      end else begin
        skid       <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (res_taken) begin
      result_valid <= 1'b0;
    end
  end

  assign igniter_on      = res.igniter_on;
  assign valve_out       = res.valve_out;
  assign blower_level    = res.blower_level;
  assign blower_off      = res.blower_off;
  assign fan_drive_level = res.fan_drive_level;
  assign dc_fan_off      = res.dc_fan_off;
  assign next_state      = res.next_state;
  assign fault_code      = res.fault_code;

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  typedef struct packed {
    logic        action;
    logic        flame_present;
    logic        water_flow;
    logic        burn_allowed;
    logic        thermal_switch;
    logic        valve_fault;
    logic        fan_running;
    logic [15:0] fan_speed;
    logic        outlet_probe_fault;
    logic        inlet_probe_fault;
    logic        flue_probe_fault;
    logic        debug_mode;
  } burner_item_t;

  localparam logic ActStart = 1'b0;
  localparam logic ActTick  = 1'b1;

  localparam bit [10:0] PurgeLast      = 11'd40;
  localparam bit [10:0] RampLast       = 11'd50;
  localparam bit [10:0] PauseFirst     = 11'd800;
  localparam bit [10:0] ReigniteAt     = 11'd1100;
  localparam bit [7:0]  FlameProven    = 8'd30;
  localparam bit [15:0] FlameOutTicks  = 16'd100;
  localparam bit [15:0] FanStallTicks  = 16'd100;
  localparam bit [15:0] OverspeedCount = 16'd50;
  localparam bit [8:0]  LevelBoost     = 9'd5;
  localparam bit [8:0]  LevelCap       = 9'd255;
  localparam bit [7:0]  BlowerFull     = 8'hff;

  class ignition_scoreboard;
    bit        boost_on;
    bit [7:0]  ign_level;
    bit [7:0]  pause_drive;
    bit [15:0] speed_limit;
    bit [7:0]  fire_pattern;
    bit [7:0]  retry_load;

    bit [10:0] timer;
    bit [7:0]  retries;
    bit [7:0]  flame_run;
    bit [15:0] flame_hold;
    bit [15:0] fan_dead;
    bit [15:0] fan_fast;

    result_t   awaited_outputs[$];
    int        errors;

    function new();
      speed_limit = 16'hffff;
      retry_load  = 8'd1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] data);
      case (idx)
        CFG_BOOST_MODE:         boost_on     = data[0];
        CFG_IGNITION_LEVEL:     ign_level    = data[7:0];
        CFG_PAUSE_LEVEL:        pause_drive  = data[7:0];
        CFG_FAN_SPEED_LIMIT:    speed_limit  = data;
        CFG_FIRE_VALVE_PATTERN: fire_pattern = data[7:0];
        CFG_RETRY_COUNT:        retry_load   = data[7:0];
        default: ;
      endcase
    endfunction

    function bit [15:0] bump(bit [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function void accept_item(burner_item_t it);
      result_t  r;
      bit [8:0] lvl;
      fault_t   probe;
      r = '0;
      r.next_state = NS_STAY;
      r.fault_code = FLT_NONE;
      if (it.action == ActStart) begin
        timer      = '0;
        flame_run  = '0;
        flame_hold = '0;
        fan_dead   = '0;
        fan_fast   = '0;
        retries    = retry_load;
        awaited_outputs.push_back(r);
        return;
      end

      // level is taken before this tick's retry bookkeeping
      lvl = {1'b0, ign_level};
      if (boost_on || retries == 8'd0) begin
        lvl = lvl + LevelBoost;
        if (lvl > LevelCap) lvl = LevelCap;
      end

      timer = timer + 11'd1;
      if (timer <= PurgeLast) begin
        r.igniter_on      = 1'b1;
        r.blower_level    = BlowerFull;
        r.fan_drive_level = lvl[7:0];
        flame_hold        = '0;
      end else if (timer <= RampLast) begin
        r.igniter_on      = 1'b1;
        r.blower_level    = lvl[7:0];
        r.fan_drive_level = lvl[7:0];
        flame_hold        = '0;
      end else if (timer >= ReigniteAt) begin
        if (retries != 8'd0) retries--;
        timer             = '0;
        r.igniter_on      = 1'b1;
        r.blower_level    = BlowerFull;
        r.fan_drive_level = lvl[7:0];
        flame_hold        = '0;
      end else if (timer >= PauseFirst) begin
        if (retries == 8'd0) begin
          r.fault_code = FLT_E1;
          r.next_state = NS_END;
        end
        r.blower_off      = 1'b1;
        r.fan_drive_level = pause_drive;
      end else begin
        r.igniter_on      = 1'b1;
        r.valve_out       = fire_pattern;
        r.blower_level    = lvl[7:0];
        r.fan_drive_level = lvl[7:0];
        if (flame_run > FlameProven) begin
          flame_run    = '0;
          r.igniter_on = 1'b0;
          if (it.debug_mode) r.next_state = NS_DEBUG;
          else r.next_state = NS_STABLE;
        end
      end

      if (it.flame_present) begin
        if (flame_run != 8'hff) flame_run++;
        flame_hold = bump(flame_hold);
      end else begin
        flame_run  = '0;
        flame_hold = '0;
      end
      if (flame_hold >= FlameOutTicks) begin
        r.fault_code = FLT_E6;
        r.next_state = NS_END;
      end

      if (!it.burn_allowed || !it.water_flow) r.next_state = NS_END;

      if (it.thermal_switch || it.valve_fault) begin
        r.fault_code = FLT_E3;
        r.next_state = NS_END;
      end

      if (it.fan_running) fan_dead = '0;
      fan_dead = bump(fan_dead);
      if (fan_dead >= FanStallTicks) begin
        r.dc_fan_off = 1'b1;
        r.fault_code = FLT_E2;
        r.next_state = NS_END;
      end

      if (it.fan_speed < speed_limit) fan_fast = '0;
      fan_fast = bump(fan_fast);
      if (fan_fast >= OverspeedCount) begin
        r.fault_code = FLT_E8;
        r.next_state = NS_END;
      end

      // flue probe outranks inlet, inlet outranks outlet
      probe = FLT_NONE;
      if (it.outlet_probe_fault) probe = FLT_E4;
      if (it.inlet_probe_fault) probe = FLT_F3;
      if (it.flue_probe_fault) probe = FLT_F5;
      if (probe != FLT_NONE) begin
        r.fault_code = probe;
        r.next_state = NS_END;
      end

      awaited_outputs.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_outputs(result_t got);
      result_t want;
      if (awaited_outputs.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      want = awaited_outputs.pop_front();
      compare_field("igniter_on", 16'(want.igniter_on), 16'(got.igniter_on));
      compare_field("valve_out", 16'(want.valve_out), 16'(got.valve_out));
      compare_field("blower_level", 16'(want.blower_level), 16'(got.blower_level));
      compare_field("blower_off", 16'(want.blower_off), 16'(got.blower_off));
      compare_field("fan_drive_level", 16'(want.fan_drive_level),
                    16'(got.fan_drive_level));
      compare_field("dc_fan_off", 16'(want.dc_fan_off), 16'(got.dc_fan_off));
      compare_field("next_state", 16'(want.next_state), 16'(got.next_state));
      compare_field("fault_code", 16'(want.fault_code), 16'(got.fault_code));
    endfunction

    function bit run_clean();
      if (awaited_outputs.size() != 0) begin
        $error("%0d results never arrived", awaited_outputs.size());
        errors++;
      end
      return errors == 0;
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  cfg_idx_t     cfg_index;
  logic [15:0]  cfg_data;
  logic         item_valid;
  logic         item_stall;
  burner_item_t item_bus;
  logic         result_valid;
  logic         result_stall;
  logic         igniter_on;
  logic [7:0]   valve_out;
  logic [7:0]   blower_level;
  logic         blower_off;
  logic [7:0]   fan_drive_level;
  logic         dc_fan_off;
  logic [1:0]   next_state;
  logic [3:0]   fault_code;

  ignition_scoreboard sb = new();

  int items_offered = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_left     = 0;

  burner_ignition_sequencer dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .action             (item_bus.action),
    .flame_present      (item_bus.flame_present),
    .water_flow         (item_bus.water_flow),
    .burn_allowed       (item_bus.burn_allowed),
    .thermal_switch     (item_bus.thermal_switch),
    .valve_fault        (item_bus.valve_fault),
    .fan_running        (item_bus.fan_running),
    .fan_speed          (item_bus.fan_speed),
    .outlet_probe_fault (item_bus.outlet_probe_fault),
    .inlet_probe_fault  (item_bus.inlet_probe_fault),
    .flue_probe_fault   (item_bus.flue_probe_fault),
    .debug_mode         (item_bus.debug_mode),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .igniter_on         (igniter_on),
    .valve_out          (valve_out),
    .blower_level       (blower_level),
    .blower_off         (blower_off),
    .fan_drive_level    (fan_drive_level),
    .dc_fan_off         (dc_fan_off),
    .next_state         (next_state),
    .fault_code         (fault_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("[burner_ignition_sequencer] ERROR");
    $finish;
  end

  // downstream side: random stalls, or a counted hold-off when one is requested
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) sb.accept_item(item_bus);
      if (result_valid && !result_stall)
        sb.check_outputs(result_t'({igniter_on, valve_out, blower_level, blower_off,
                                    fan_drive_level, dc_fan_off, next_state,
                                    fault_code}));
    end
  end

  function bit rare(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function burner_item_t any_item();
    burner_item_t it;
    it = burner_item_t'($bits(burner_item_t)'({$urandom, $urandom}));
    it.fan_speed = 16'($urandom_range(65535));
    return it;
  endfunction

  function burner_item_t healthy_tick();
    burner_item_t it;
    it = '0;
    it.action       = ActTick;
    it.water_flow   = 1'b1;
    it.burn_allowed = 1'b1;
    it.fan_running  = 1'b1;
    return it;
  endfunction

  function logic [15:0] speed_for(bit fast);
    logic [15:0] lim;
    lim = sb.speed_limit;
    if ($urandom_range(15) == 0) return 16'($urandom_range(65535));
    if (fast) return 16'($urandom_range(65535, lim));
    if (lim == 16'd0) return 16'($urandom_range(65535));
    return 16'($urandom_range(lim - 16'd1, 0));
  endfunction

  task send_item(burner_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_bus   <= it;
    do @(posedge clk); while (item_stall);
    items_offered++;
  endtask

  task wait_drained();
    item_valid <= 1'b0;
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task apply_setting(input logic [15:0] boost, ign, pause, limit, fire, retry);
    logic [15:0] vals [6];
    vals = '{boost, ign, pause, limit, fire, retry};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // An optional start then a run of ticks. Flame, fan feedback and overspeed hold
  // their level for stretches so that the counters can reach their limits.
  task run_sequence(int ticks, bit with_start, int noise_pct, int flip_odds, bit strays);
    burner_item_t it;
    bit flame;
    bit fan_ok;
    bit fast;
    flame  = 1'b0;
    fan_ok = 1'b1;
    fast   = 1'b0;
    if (with_start) begin
      it = any_item();
      it.action = ActStart;
      send_item(it);
    end
    repeat (ticks) begin
      if ($urandom_range(flip_odds - 1) == 0) flame = !flame;
      if ($urandom_range(flip_odds - 1) == 0) fan_ok = !fan_ok;
      if ($urandom_range(flip_odds - 1) == 0) fast = !fast;
      if (strays && $urandom_range(49) == 0) begin
        it = any_item();
      end else begin
        it.action             = ActTick;
        it.flame_present      = flame;
        it.water_flow         = !rare(noise_pct);
        it.burn_allowed       = !rare(noise_pct);
        it.thermal_switch     = rare(noise_pct);
        it.valve_fault        = rare(noise_pct);
        it.fan_running        = fan_ok;
        it.fan_speed          = speed_for(fast);
        it.outlet_probe_fault = rare(noise_pct);
        it.inlet_probe_fault  = rare(noise_pct);
        it.flue_probe_fault   = rare(noise_pct);
        it.debug_mode         = 1'($urandom_range(1));
      end
      send_item(it);
    end
  endtask

  task run_random(int budget);
    int first;
    int sel;
    int odds;
    int len;
    int left;
    first = items_offered;
    while (items_offered - first < budget) begin
      left = budget - (items_offered - first);
      sel  = $urandom_range(9);
      odds = ($urandom_range(2) == 0) ? 8 : (($urandom_range(1) == 0) ? 40 : 250);
      len  = (sel == 0) ? int'($urandom_range(40, 1)) : int'($urandom_range(250, 2));
      if (len > left) len = left;
      if (sel == 0)
        run_sequence(len, 1'($urandom_range(1)), 50, 4, 1'b1);
      else
        run_sequence(len, $urandom_range(7) != 0,
                     ($urandom_range(1) == 0) ? 0 : 3, odds, 1'b1);
    end
  endtask

  initial begin
    burner_item_t it;
    rst        = 1'b1;
    item_valid = 1'b0;
    item_bus   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_BOOST_MODE;
    cfg_data   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed beats on reset register values
    it = healthy_tick();                  // tick before any start, no retries left
    send_item(it);
    it = '1; it.action = ActStart;        // start with every other field high
    send_item(it);
    it = '1;                              // everything raised at once
    send_item(it);
    it = '0; it.action = ActTick;         // interlocks open, fan stopped
    send_item(it);
    it = healthy_tick(); it.thermal_switch = 1'b1;
    send_item(it);
    it = healthy_tick(); it.valve_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.burn_allowed = 1'b0;
    send_item(it);
    it = healthy_tick(); it.water_flow = 1'b0;
    send_item(it);
    it = healthy_tick(); it.outlet_probe_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.inlet_probe_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.flue_probe_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.outlet_probe_fault = 1'b1; it.inlet_probe_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.inlet_probe_fault = 1'b1; it.flue_probe_fault = 1'b1;
    send_item(it);
    it = healthy_tick(); it.fan_speed = 16'hffff;
    send_item(it);
    it = healthy_tick(); it.flame_present = 1'b1; it.debug_mode = 1'b1;
    send_item(it);
    it = '0; it.action = ActStart;
    send_item(it);
    it = healthy_tick(); it.fan_running = 1'b0;
    send_item(it);

    // no idling; no retries, so the pause raises E1 and re-ignition stays at zero
    apply_setting(16'd0, 16'd250, 16'd255, 16'hffff, 16'h00ff, 16'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_sequence(1100 + $urandom_range(40), 1'b1, 1, 250, 1'b0);
    hold_left = 80;   // downstream holds off while beats keep coming
    run_random(40);

    apply_setting(16'd1, 16'd0, 16'd0, 16'($urandom_range(65535, 1)), 16'd0, 16'd255);
    tx_idle_pct  = 74;
    rx_stall_pct = 0;
    run_random(40);

    // ignition level at the top so the boost saturates
    apply_setting(16'd1, 16'd255, 16'($urandom_range(255)), 16'd0,
                  16'($urandom_range(255)), 16'($urandom_range(3)));
    tx_idle_pct  = 0;
    rx_stall_pct = 74;
    run_random(40);

    // one retry loaded at start
    apply_setting(16'd0, 16'($urandom_range(250)), 16'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(255)), 16'd1);
    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    run_random(40);

    wait_drained();
    if (sb.run_clean())
      $display("[burner_ignition_sequencer] OK");
    else
      $display("[burner_ignition_sequencer] ERROR");
    $finish;
  end

endmodule

// File: files.f
hdl/bis_pkg.sv
hdl/burner_ignition_sequencer.sv
tb/tb.sv
